// ----- rtl/rcw_pkg.sv -----
// Shared types, constants and helpers for the credit-window controller.
package rcw_pkg;

  localparam int unsigned RESERVED_ENTRIES = 3;
  localparam int unsigned CreditW = 16;
  localparam logic [CreditW-1:0] CREDIT_MAX = '1;
  localparam logic [1:0] ACK_SLOT_MAX = 2'd3;
  localparam logic [CreditW-1:0] RESERVE = CreditW'(RESERVED_ENTRIES);

  typedef logic [CreditW-1:0] credit_t;

  typedef enum logic [1:0] {
    CMD_START     = 2'd0,
    CMD_SEND      = 2'd1,
    CMD_SEND_DONE = 2'd2,
    CMD_RECV_DONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_SEND_QUEUE_DEPTH = 2'd0,
    CFG_RECV_QUEUE_DEPTH = 2'd1,
    CFG_PEER_SEND_DEPTH  = 2'd2,
    CFG_PEER_RECV_DEPTH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    last_in_batch;
    credit_t done_count;
    logic    has_payload;
    logic    imm_present;
    credit_t imm_credits;
  } rcw_req_t;

  typedef struct packed {
    logic    granted;
    logic    ack_post;
    credit_t credit_value;
    logic    solicited;
    logic    signaled;
    credit_t signal_count;
    logic    wake_writer;
    logic    writable;
  } rcw_rsp_t;

  // Add two credit counts, clamp at the counter maximum.
  function automatic credit_t sat_add(input credit_t a, input credit_t b);
    logic [CreditW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CreditW] ? CREDIT_MAX : s[CreditW-1:0];
  endfunction

  // Smaller of two depths less the reserve, floored at zero.
  function automatic credit_t capacity(input credit_t a, input credit_t b);
    credit_t m;
    m = (a < b) ? a : b;
    return (m > RESERVE) ? (m - RESERVE) : '0;
  endfunction

endpackage

// ----- rtl/rcw_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface rcw_in_if;
  import rcw_pkg::*;
  logic     valid;
  logic     ready;
  rcw_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcw_out_if;
  import rcw_pkg::*;
  logic     valid;
  logic     ready;
  rcw_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rdma_credit_window_control.sv -----
// Credit-window flow control engine for one reliable RDMA send/receive pair.
//
//   channel  | dir | handshake            | beat contents
//   in_bus   | in  | valid/ready          | cmd, batch flag, done count, recv flags, credits
//   out_bus  | out | valid/ready          | grant, ack post, flags, counts, wake, writable
//   cfg_*    | in  | cfg_we, no back-press| queue depth registers 0..3
//
// One request beat per cycle while in_bus.ready is high; one response beat per request, valid the cycle after it.
// All state updates happen at the request beat; the response lands in an output register.
// in_bus.ready stays high while the output register is empty or being drained,
// so a stalled sink only holds the pipe once a response is waiting.
// Synchronous active-low reset: windows and counters clear, ack slots return to three,
// depth registers return to 128.
module rdma_credit_window_control (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  rcw_pkg::cfg_idx_t      cfg_idx,
  input  rcw_pkg::credit_t       cfg_wdata,
  rcw_in_if.sink                 in_bus,
  rcw_out_if.source              out_bus
);
  import rcw_pkg::*;

  localparam credit_t DEPTH_RESET = credit_t'(128);

  // Negotiated depths, used only when a start beat latches them.
  credit_t sq_depth_r, rq_depth_r, peer_sq_depth_r, peer_rq_depth_r;

  // Window and batching state.
  credit_t    send_credit_r, send_credit_nxt;
  credit_t    peer_recv_credit_r, peer_recv_credit_nxt;
  logic [1:0] ack_slot_r, ack_slot_nxt;
  credit_t    pending_acks_r, pending_acks_nxt;
  credit_t    unsolicited_r, unsolicited_nxt;
  credit_t    accum_credit_r, accum_credit_nxt;
  credit_t    unsignaled_r, unsignaled_nxt;
  credit_t    local_cap_r, local_cap_nxt;
  credit_t    remote_cap_r, remote_cap_nxt;

  // Output register.
  logic     out_valid_r;
  rcw_rsp_t out_data_r, out_data_nxt;

  logic in_fire;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  // Configuration writes: take whenever cfg_we is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_depth_r      <= DEPTH_RESET;
      rq_depth_r      <= DEPTH_RESET;
      peer_sq_depth_r <= DEPTH_RESET;
      peer_rq_depth_r <= DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SEND_QUEUE_DEPTH: sq_depth_r      <= cfg_wdata;
        CFG_RECV_QUEUE_DEPTH: rq_depth_r      <= cfg_wdata;
        CFG_PEER_SEND_DEPTH:  peer_sq_depth_r <= cfg_wdata;
        CFG_PEER_RECV_DEPTH:  peer_rq_depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Single-pass update for one request beat.
  always_comb begin
    rcw_req_t   req;
    credit_t    lc_q, lc_e, rc_q, rc_h;
    logic       grant, sol;
    credit_t    unsig_inc;
    logic       ack_path;
    logic [1:0] slot_base;
    credit_t    ack_add, pend_sum;
    logic       ack_fire;
    credit_t    sc_left, prc_left;

    req = in_bus.data;
    lc_q = local_cap_r >> 2;
    lc_e = local_cap_r >> 3;
    rc_q = remote_cap_r >> 2;
    rc_h = remote_cap_r >> 1;

    send_credit_nxt      = send_credit_r;
    peer_recv_credit_nxt = peer_recv_credit_r;
    ack_slot_nxt         = ack_slot_r;
    pending_acks_nxt     = pending_acks_r;
    unsolicited_nxt      = unsolicited_r;
    accum_credit_nxt     = accum_credit_r;
    unsignaled_nxt       = unsignaled_r;
    local_cap_nxt        = local_cap_r;
    remote_cap_nxt       = remote_cap_r;
    out_data_nxt         = '0;

    grant     = (send_credit_r != '0) && (peer_recv_credit_r != '0);
    sol       = 1'b0;
    unsig_inc = sat_add(unsignaled_r, credit_t'(1));
    sc_left   = send_credit_r - credit_t'(1);
    prc_left  = peer_recv_credit_r - credit_t'(1);

    // Shared ack batching for an ack send completion or a payload receive.
    ack_path  = 1'b0;
    slot_base = ack_slot_r;
    ack_add   = credit_t'(1);
    if (req.cmd == CMD_SEND_DONE) begin
      ack_path  = (req.done_count == '0);
      ack_add   = '0;
      slot_base = (ack_slot_r < ACK_SLOT_MAX) ? ack_slot_r + 2'd1 : ack_slot_r;
    end else if (req.cmd == CMD_RECV_DONE) begin
      ack_path = req.has_payload;
    end
    pend_sum = sat_add(pending_acks_r, ack_add);
    ack_fire = (pend_sum > rc_h) && (slot_base != 2'd0);

    case (req.cmd)
      CMD_START: begin
        local_cap_nxt        = capacity(sq_depth_r, peer_rq_depth_r);
        remote_cap_nxt       = capacity(rq_depth_r, peer_sq_depth_r);
        send_credit_nxt      = local_cap_nxt;
        peer_recv_credit_nxt = local_cap_nxt;
        ack_slot_nxt         = ACK_SLOT_MAX;
        pending_acks_nxt     = '0;
      end
      CMD_SEND: begin
        if (grant) begin
          pending_acks_nxt          = '0;
          out_data_nxt.granted      = 1'b1;
          out_data_nxt.credit_value = pending_acks_r;
          sol = (peer_recv_credit_r == credit_t'(1)) || (send_credit_r == credit_t'(1)) ||
                req.last_in_batch || (unsolicited_r > lc_q) || (accum_credit_r > rc_q);
          if (sol) begin
            out_data_nxt.solicited = 1'b1;
            unsolicited_nxt        = '0;
            accum_credit_nxt       = '0;
          end else begin
            unsolicited_nxt  = sat_add(unsolicited_r, credit_t'(1));
            accum_credit_nxt = sat_add(accum_credit_r, pending_acks_r);
          end
          // Request a completion once enough unsignaled sends have piled up.
          if (unsig_inc >= lc_q) begin
            out_data_nxt.signaled     = 1'b1;
            out_data_nxt.signal_count = unsig_inc;
            unsignaled_nxt            = '0;
          end else begin
            unsignaled_nxt = unsig_inc;
          end
          send_credit_nxt      = sc_left;
          peer_recv_credit_nxt = prc_left;
        end
      end
      CMD_SEND_DONE: begin
        if (req.done_count == '0) begin
          ack_slot_nxt = slot_base;
        end else begin
          send_credit_nxt          = sat_add(send_credit_r, req.done_count);
          out_data_nxt.wake_writer = (peer_recv_credit_r >= lc_e);
        end
      end
      CMD_RECV_DONE: begin
        if (req.imm_present && (req.imm_credits != '0)) begin
          peer_recv_credit_nxt     = sat_add(peer_recv_credit_r, req.imm_credits);
          out_data_nxt.wake_writer = (send_credit_r != '0) &&
                                     ((peer_recv_credit_r >= lc_e) || (req.imm_credits >= lc_e));
        end
      end
      default: ;
    endcase

    // Post a standalone ack once pending credits pass half the remote window and an ack slot is free.
    if (ack_path) begin
      pending_acks_nxt = pend_sum;
      if (ack_fire) begin
        pending_acks_nxt = '0;
        if (pend_sum != '0) begin
          out_data_nxt.ack_post     = 1'b1;
          out_data_nxt.credit_value = pend_sum;
          ack_slot_nxt              = slot_base - 2'd1;
        end
      end
    end

    out_data_nxt.writable = (send_credit_nxt != '0) && (peer_recv_credit_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_credit_r      <= '0;
      peer_recv_credit_r <= '0;
      ack_slot_r         <= ACK_SLOT_MAX;
      pending_acks_r     <= '0;
      unsolicited_r      <= '0;
      accum_credit_r     <= '0;
      unsignaled_r       <= '0;
      local_cap_r        <= '0;
      remote_cap_r       <= '0;
    end else if (in_fire) begin
      send_credit_r      <= send_credit_nxt;
      peer_recv_credit_r <= peer_recv_credit_nxt;
      ack_slot_r         <= ack_slot_nxt;
      pending_acks_r     <= pending_acks_nxt;
      unsolicited_r      <= unsolicited_nxt;
      accum_credit_r     <= accum_credit_nxt;
      unsignaled_r       <= unsignaled_nxt;
      local_cap_r        <= local_cap_nxt;
      remote_cap_r       <= remote_cap_nxt;
    end
  end

  // Output register: load on a request beat, drop when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_refuse_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_bus.data.cmd == CMD_SEND) &&
    ((send_credit_r == '0) || (peer_recv_credit_r == '0))
    |=> out_valid_r && !out_data_r.granted)
    else $error("send granted with an empty window");

  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_bus.data.cmd == CMD_START)
    |=> (send_credit_r == peer_recv_credit_r) && (ack_slot_r == ACK_SLOT_MAX) &&
        (pending_acks_r == '0))
    else $error("start did not load the windows");

  a_grant_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_bus.data.cmd == CMD_SEND) && (send_credit_r != '0) &&
    (peer_recv_credit_r != '0)
    |=> (send_credit_r == $past(send_credit_r) - credit_t'(1)) && (pending_acks_r == '0))
    else $error("granted send did not consume credit");

  a_ack_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.ack_post |-> (out_data_r.credit_value != '0) &&
    !out_data_r.granted)
    else $error("ack posted without credits");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the credit-window controller: directed table, then random phases.
module testbench;
  import rcw_pkg::*;

  // Give up once this many cycles pass with no beat on either channel.
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 8;
  localparam int BEATS_PER_PHASE = 115;
  localparam int HOLD_OFF_CYCLES = 60;

  // One row of the directed table: either a register write or a request beat.
  // A pinned row carries a hand-written response; the others use the predictor.
  typedef struct {
    logic     is_cfg;
    cfg_idx_t idx;
    credit_t  val;
    rcw_req_t req;
    logic     pinned;
    rcw_rsp_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  credit_t  cfg_wdata;

  rcw_in_if  in_bus ();
  rcw_out_if out_bus ();

  // Travel alongside in_bus.data so the monitor sees them at the same edge.
  logic     row_pinned;
  rcw_rsp_t row_want;

  // Responses still owed by the block, oldest first.
  rcw_rsp_t owed_rsp[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;

  // Shadow of the depth registers and of the controller state.
  credit_t    depth_reg [4];
  credit_t    cap_local, cap_remote;
  credit_t    win_send, win_peer;
  credit_t    pend_acks, unsol_cnt, accum_cr, unsig_cnt;
  logic [1:0] ack_slots;

  rdma_credit_window_control u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add and clamp at the top of the 16-bit range.
  function automatic credit_t clamp_add(input credit_t a, input credit_t b);
    logic [CreditW:0] s;
    s = a + b;
    return (s > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : s[CreditW-1:0];
  endfunction

  // Shallower of two depths minus the reserved entries; never below zero.
  function automatic credit_t window_size(input credit_t a, input credit_t b);
    credit_t m;
    m = (a < b) ? a : b;
    return (m > RESERVED_ENTRIES) ? credit_t'(m - RESERVED_ENTRIES) : '0;
  endfunction

  // Bank receive credits; post a standalone ack once more than half the
  // remote window has piled up and an ack slot is free.
  function automatic void gather_acks(input credit_t n, inout rcw_rsp_t rsp);
    credit_t total;
    pend_acks = clamp_add(pend_acks, n);
    if (pend_acks > cap_remote / 2 && ack_slots != 0) begin
      total = pend_acks;
      pend_acks = '0;
      if (total != 0) begin
        rsp.ack_post = 1'b1;
        rsp.credit_value = total;
        ack_slots = ack_slots - 1'b1;
      end
    end
  endfunction

  // Apply one request to the shadow windows and return the response it owes.
  function automatic rcw_rsp_t advance_windows(input rcw_req_t r);
    rcw_rsp_t rsp;
    credit_t  carried, prev_peer;
    logic     sol;
    rsp = '0;
    case (r.cmd)
      CMD_START: begin
        // Latch capacities; the solicit and signal counters survive a start.
        cap_local = window_size(depth_reg[CFG_SEND_QUEUE_DEPTH], depth_reg[CFG_PEER_RECV_DEPTH]);
        cap_remote = window_size(depth_reg[CFG_RECV_QUEUE_DEPTH], depth_reg[CFG_PEER_SEND_DEPTH]);
        win_send = cap_local;
        win_peer = cap_local;
        ack_slots = ACK_SLOT_MAX;
        pend_acks = '0;
      end
      CMD_SEND: begin
        if (win_send != 0 && win_peer != 0) begin
          carried = pend_acks;
          pend_acks = '0;
          rsp.granted = 1'b1;
          rsp.credit_value = carried;
          sol = (win_peer == 1) || (win_send == 1) || r.last_in_batch ||
                (unsol_cnt > cap_local / 4) || (accum_cr > cap_remote / 4);
          if (sol) begin
            rsp.solicited = 1'b1;
            unsol_cnt = '0;
            accum_cr = '0;
          end else begin
            unsol_cnt = clamp_add(unsol_cnt, credit_t'(1));
            accum_cr = clamp_add(accum_cr, carried);
          end
          unsig_cnt = clamp_add(unsig_cnt, credit_t'(1));
          if (unsig_cnt >= cap_local / 4) begin
            rsp.signaled = 1'b1;
            rsp.signal_count = unsig_cnt;
            unsig_cnt = '0;
          end
          win_send = win_send - 1'b1;
          win_peer = win_peer - 1'b1;
        end
      end
      CMD_SEND_DONE: begin
        if (r.done_count == 0) begin
          // Completion of an ack send frees an ack slot.
          if (ack_slots < ACK_SLOT_MAX) ack_slots = ack_slots + 1'b1;
          gather_acks('0, rsp);
        end else begin
          win_send = clamp_add(win_send, r.done_count);
          if (win_peer >= cap_local / 8) rsp.wake_writer = 1'b1;
        end
      end
      CMD_RECV_DONE: begin
        if (r.imm_present && r.imm_credits != 0) begin
          prev_peer = win_peer;
          win_peer = clamp_add(win_peer, r.imm_credits);
          if (win_send != 0 && (prev_peer >= cap_local / 8 || r.imm_credits >= cap_local / 8))
            rsp.wake_writer = 1'b1;
        end
        if (r.has_payload) gather_acks(credit_t'(1), rsp);
      end
      default: ;
    endcase
    rsp.writable = (win_send != 0) && (win_peer != 0);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Table and stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rcw_req_t req_of(input cmd_t c, input logic last, input credit_t done,
                                      input logic pay, input logic immp, input credit_t imm);
    rcw_req_t r;
    r.cmd = c;
    r.last_in_batch = last;
    r.done_count = done;
    r.has_payload = pay;
    r.imm_present = immp;
    r.imm_credits = imm;
    return r;
  endfunction

  function automatic rcw_rsp_t rsp_of(input logic grant, input logic ack, input credit_t credit,
                                      input logic sol, input logic sig, input credit_t cnt,
                                      input logic wake, input logic wr);
    rcw_rsp_t p;
    p.granted = grant;
    p.ack_post = ack;
    p.credit_value = credit;
    p.solicited = sol;
    p.signaled = sig;
    p.signal_count = cnt;
    p.wake_writer = wake;
    p.writable = wr;
    return p;
  endfunction

  function automatic dir_row_t beat_row(input rcw_req_t r);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx = CFG_SEND_QUEUE_DEPTH;
    row.val = '0;
    row.req = r;
    row.pinned = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t pin_row(input rcw_req_t r, input rcw_rsp_t want);
    dir_row_t row;
    row = beat_row(r);
    row.pinned = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_idx_t idx, input credit_t val);
    dir_row_t row;
    row = beat_row('0);
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  // Depth for one register in a given phase: low extreme, high extreme, a
  // phase that often starves a window, and random mixes otherwise.
  function automatic credit_t pick_depth(input int phase);
    int r;
    r = $urandom_range(7);
    if (phase == 0) return credit_t'(16);
    if (phase == 1) return CREDIT_MAX;
    if (phase == 3)
      return (r < 2) ? credit_t'($urandom_range(4)) : credit_t'($urandom_range(16, 40));
    if (r == 0) return credit_t'($urandom_range(65535));
    if (r == 1) return credit_t'($urandom_range(5));
    return credit_t'($urandom_range(16, 64));
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Offer one request beat, with random idle gaps in front, and hold it until taken.
  task automatic offer_beat(input rcw_req_t r, input logic pinned, input rcw_rsp_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= r;
    row_pinned <= pinned;
    row_want <= want;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed response is back, plus the pipe latency.
  task automatic drain_beats();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Single register write; the shadow follows so the next start latches it.
  task automatic write_depth(input cfg_idx_t idx, input credit_t val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    depth_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: score responses first, then book the request taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    rcw_rsp_t want, pred;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (owed_rsp.size() == 0) begin
          report_mismatch("unexpected beat, credit_value", out_bus.data.credit_value, '0);
        end else begin
          want = owed_rsp.pop_front();
          if (out_bus.data.granted !== want.granted)
            report_mismatch("granted", credit_t'(out_bus.data.granted),
                            credit_t'(want.granted));
          if (out_bus.data.ack_post !== want.ack_post)
            report_mismatch("ack_post", credit_t'(out_bus.data.ack_post),
                            credit_t'(want.ack_post));
          if (out_bus.data.credit_value !== want.credit_value)
            report_mismatch("credit_value", out_bus.data.credit_value, want.credit_value);
          if (out_bus.data.solicited !== want.solicited)
            report_mismatch("solicited", credit_t'(out_bus.data.solicited),
                            credit_t'(want.solicited));
          if (out_bus.data.signaled !== want.signaled)
            report_mismatch("signaled", credit_t'(out_bus.data.signaled),
                            credit_t'(want.signaled));
          if (out_bus.data.signal_count !== want.signal_count)
            report_mismatch("signal_count", out_bus.data.signal_count, want.signal_count);
          if (out_bus.data.wake_writer !== want.wake_writer)
            report_mismatch("wake_writer", credit_t'(out_bus.data.wake_writer),
                            credit_t'(want.wake_writer));
          if (out_bus.data.writable !== want.writable)
            report_mismatch("writable", credit_t'(out_bus.data.writable),
                            credit_t'(want.writable));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        // Always advance the shadow, even when the row carries its own answer.
        pred = advance_windows(in_bus.data);
        owed_rsp.push_back(row_pinned ? row_want : pred);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Response sink: random stalls, or a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        // Hold ready low long enough for the output register to fill and
        // back-pressure the request side.
        out_bus.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    dir_row_t rows[$];
    rcw_req_t req;
    cmd_t     pick;
    int       c, d, e;

    // Drive every input to a known value before the first edge.
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_SEND_QUEUE_DEPTH;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.data <= '0;
    row_pinned <= 1'b0;
    row_want <= '0;

    // Shadow state matches the block after reset.
    foreach (depth_reg[i]) depth_reg[i] = credit_t'(128);
    cap_local = '0;
    cap_remote = '0;
    win_send = '0;
    win_peer = '0;
    pend_acks = '0;
    unsol_cnt = '0;
    accum_cr = '0;
    unsig_cnt = '0;
    ack_slots = ACK_SLOT_MAX;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Before any start both windows are empty and the remote
    // capacity is zero, so a single payload receive already posts an ack.
    rows.push_back(pin_row(req_of(CMD_SEND, 1'b1, '1, 1'b1, 1'b1, '1), '0));
    rows.push_back(pin_row(req_of(CMD_SEND_DONE, 1'b0, '0, 1'b0, 1'b0, '0), '0));
    rows.push_back(pin_row(req_of(CMD_RECV_DONE, 1'b0, '0, 1'b1, 1'b0, '0),
                           rsp_of(1'b0, 1'b1, credit_t'(1), 1'b0, 1'b0, '0, 1'b0, 1'b0)));
    // Reset depths of 128 give windows of 125.
    rows.push_back(pin_row(req_of(CMD_START, 1'b0, '0, 1'b0, 1'b0, '0),
                           rsp_of(1'b0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(pin_row(req_of(CMD_SEND, 1'b1, '1, 1'b1, 1'b1, '1),
                           rsp_of(1'b1, 1'b0, '0, 1'b1, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(beat_row(req_of(CMD_SEND, 1'b0, '0, 1'b0, 1'b0, '0)));
    rows.push_back(beat_row(req_of(CMD_RECV_DONE, 1'b0, '0, 1'b1, 1'b1, '1)));
    rows.push_back(beat_row(req_of(CMD_SEND_DONE, 1'b1, '1, 1'b1, 1'b1, '1)));
    rows.push_back(beat_row(req_of(CMD_SEND_DONE, 1'b0, '0, 1'b0, 1'b0, '0)));
    rows.push_back(beat_row(req_of(CMD_RECV_DONE, 1'b1, '1, 1'b0, 1'b0, '1)));
    rows.push_back(beat_row(req_of(CMD_RECV_DONE, 1'b0, '0, 1'b0, 1'b1, '0)));
    rows.push_back(beat_row(req_of(CMD_START, 1'b1, '1, 1'b1, 1'b1, '1)));
    // Send depth under the reserve: the local capacity floors at zero.
    rows.push_back(cfg_row(CFG_SEND_QUEUE_DEPTH, credit_t'(2)));
    rows.push_back(cfg_row(CFG_RECV_QUEUE_DEPTH, CREDIT_MAX));
    rows.push_back(cfg_row(CFG_PEER_SEND_DEPTH, CREDIT_MAX));
    rows.push_back(cfg_row(CFG_PEER_RECV_DEPTH, CREDIT_MAX));
    rows.push_back(pin_row(req_of(CMD_START, 1'b0, '0, 1'b0, 1'b0, '0), '0));
    rows.push_back(pin_row(req_of(CMD_SEND, 1'b0, '0, 1'b0, 1'b0, '0), '0));
    rows.push_back(pin_row(req_of(CMD_SEND_DONE, 1'b0, credit_t'(1), 1'b0, 1'b0, '0),
                           rsp_of(1'b0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b1, 1'b0)));
    rows.push_back(beat_row(req_of(CMD_RECV_DONE, 1'b0, '0, 1'b0, 1'b1, credit_t'(1))));
    rows.push_back(beat_row(req_of(CMD_SEND, 1'b0, '0, 1'b0, 1'b0, '0)));
    // Depths of 16 on the peer side and receive queue: windows of 13.
    rows.push_back(cfg_row(CFG_SEND_QUEUE_DEPTH, CREDIT_MAX));
    rows.push_back(cfg_row(CFG_RECV_QUEUE_DEPTH, credit_t'(16)));
    rows.push_back(cfg_row(CFG_PEER_SEND_DEPTH, credit_t'(16)));
    rows.push_back(cfg_row(CFG_PEER_RECV_DEPTH, credit_t'(16)));
    rows.push_back(pin_row(req_of(CMD_START, 1'b0, '0, 1'b0, 1'b0, '0),
                           rsp_of(1'b0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1)));
    rows.push_back(beat_row(req_of(CMD_SEND, 1'b0, '0, 1'b0, 1'b0, '0)));
    rows.push_back(beat_row(req_of(CMD_RECV_DONE, 1'b0, '0, 1'b1, 1'b1, credit_t'(2))));
    rows.push_back(beat_row(req_of(CMD_SEND, 1'b0, '0, 1'b0, 1'b0, '0)));
    rows.push_back(beat_row(req_of(CMD_SEND_DONE, 1'b0, credit_t'(3), 1'b0, 1'b0, '0)));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_beats();
        write_depth(rows[i].idx, rows[i].val);
      end else begin
        offer_beat(rows[i].req, rows[i].pinned, rows[i].want);
      end
    end

    // Random phases: new depths each phase, rotating through the idle modes.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_beats();
      write_depth(CFG_SEND_QUEUE_DEPTH, pick_depth(phase));
      write_depth(CFG_RECV_QUEUE_DEPTH, pick_depth(phase));
      write_depth(CFG_PEER_SEND_DEPTH, pick_depth(phase));
      write_depth(CFG_PEER_RECV_DEPTH, pick_depth(phase));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      // Open every phase with a start so the windows are loaded.
      offer_beat(req_of(CMD_START, 1'b0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        // Stall the sink for a long stretch while requests keep coming.
        if (phase == 4 && k == 40) hold_len = HOLD_OFF_CYCLES;
        // Pause the request side until everything owed has come back.
        if (phase == 5 && k == 50) drain_beats();
        c = $urandom_range(99);
        d = $urandom_range(9);
        e = $urandom_range(9);
        if (c < 3) pick = CMD_START;
        else if (c < 50) pick = CMD_SEND;
        else if (c < 72) pick = CMD_SEND_DONE;
        else pick = CMD_RECV_DONE;
        // Mostly small credit returns to keep the windows cycling; some ack
        // sends, zero-credit immediates and full-range values.
        req = req_of(pick, $urandom_range(3) == 0,
                     (d == 0) ? credit_t'(0) :
                     (d == 1) ? credit_t'($urandom_range(65535)) :
                                credit_t'($urandom_range(1, 8)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     (e == 0) ? credit_t'(0) :
                     (e == 1) ? credit_t'($urandom_range(65535)) :
                                credit_t'($urandom_range(1, 6)));
        offer_beat(req, 1'b0, '0);
      end
    end

    drain_beats();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
